### hdl/blist_pkg.sv
// ----------------------------------------------------------------------------
// blist_pkg
// Shared types and constants for the bounded list engine: operation kinds,
// status codes, beat field widths and the default list depth.
// ----------------------------------------------------------------------------
`default_nettype none

package blist_pkg;

    // Default number of elements the list can hold
    localparam int DEPTH_DEFAULT = 128;

    // Beat field widths
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int DATA_W   = 32;
    localparam int LENGTH_W = 8;
    localparam int STATUS_W = 2;

    // Packed beat widths, padded to whole bytes
    localparam int S_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + LENGTH_W + 1 + STATUS_W + 7) / 8) * 8;

    // Operation carried on s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_LEFT    = 3'd0,
        KIND_ADD_RIGHT   = 3'd1,
        KIND_READ_HEAD   = 3'd2,
        KIND_REMOVE_HEAD = 3'd3,
        KIND_READ_AT     = 3'd4,
        KIND_TAKE        = 3'd5,
        KIND_DROP        = 3'd6
    } kind_t;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

`default_nettype wire

### hdl/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_list_engine
// Bounded ordered list held in a ring-buffer memory with a front pointer.
// ----------------------------------------------------------------------------
// One operation is taken per cycle unless a result waits on m_tready, and its
// result beat appears on the master side in the cycle after the operation
// beat is accepted, so the sustained rate is one operation per clock while
// m_tready is high. Each operation makes at most one access to the single-port
// element memory; pointer and length are updated at acceptance, so the next
// operation sees them at once. The memory's read register doubles as the
// result register and holds while m_tready is low; s_tready follows it and
// is held low during reset. No memory initialisation is needed after reset:
// entries are only ever read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_engine #(
    parameter int DEPTH = blist_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Operation beats
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [blist_pkg::S_TDATA_W-1:0] s_tdata,   // value[31:0], count[39:32]
    input  wire logic [blist_pkg::KIND_W-1:0]    s_tuser,   // kind[2:0]
    // Result beats
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [blist_pkg::M_TDATA_W-1:0] m_tdata    // data[31:0], length[39:32],
                                                            // empty_flag[40], status[42:41]
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = ((CW > blist_pkg::COUNT_W) ? CW : blist_pkg::COUNT_W) + 1;
    localparam int VW  = blist_pkg::VALUE_W;
    localparam int NW  = blist_pkg::COUNT_W;
    localparam int DW  = blist_pkg::DATA_W;
    localparam int LW  = blist_pkg::LENGTH_W;
    localparam int PAD = blist_pkg::M_TDATA_W - (DW + LW + 1 + blist_pkg::STATUS_W);

    // List state
    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    // Result stage
    logic                valid_reg;
    logic                rd_reg, rd_next;
    logic [LW-1:0]       length_reg;
    logic                empty_reg;
    blist_pkg::status_t  status_reg, status_next;

    // Decoded beat
    blist_pkg::kind_t kind;
    logic [VW-1:0]    value;
    logic [NW-1:0]    n;
    logic             accept;

    // Ring arithmetic
    logic [SW-1:0] n_ext, cnt_ext, off_ext, sum, cnt_next_ext;
    logic [PW-1:0] wrap_pos, left_pos;
    logic          full;

    // Memory access
    logic          ram_en, ram_we;
    logic [PW-1:0] ram_addr;
    logic [DW-1:0] ram_q;

    assign kind   = blist_pkg::kind_t'(s_tuser);
    assign value  = s_tdata[VW-1:0];
    assign n      = s_tdata[VW+NW-1:VW];
    assign accept = s_tvalid && s_tready;

    assign s_tready = aresetn && (!valid_reg || m_tready);

    // front + offset, wrapped once; offset is below DEPTH wherever used
    assign n_ext    = SW'(n);
    assign cnt_ext  = SW'(count_reg);
    assign off_ext  = (kind == blist_pkg::KIND_ADD_RIGHT) ? cnt_ext : n_ext;
    assign sum      = SW'(front_reg) + off_ext;
    assign wrap_pos = (sum >= SW'(DEPTH)) ? PW'(sum - SW'(DEPTH)) : PW'(sum);
    assign left_pos = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);
    assign full     = (count_reg == CW'(DEPTH));

    // Operation decode
    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = blist_pkg::ST_OK;
        rd_next     = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = front_reg;
        case (kind)
            blist_pkg::KIND_ADD_LEFT: begin
                if (full) begin
                    status_next = blist_pkg::ST_FULL;
                end else begin
                    front_next = left_pos;
                    count_next = count_reg + CW'(1);
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = left_pos;
                end
            end
            blist_pkg::KIND_ADD_RIGHT: begin
                if (full) begin
                    status_next = blist_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = wrap_pos;
                end
            end
            blist_pkg::KIND_READ_HEAD: begin
                if (count_reg == '0) begin
                    status_next = blist_pkg::ST_EMPTY;
                end else begin
                    rd_next = 1'b1;
                    ram_en  = 1'b1;
                end
            end
            blist_pkg::KIND_REMOVE_HEAD: begin
                if (count_reg == '0) begin
                    status_next = blist_pkg::ST_EMPTY;
                end else begin
                    front_next = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + PW'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            blist_pkg::KIND_READ_AT: begin
                if (n_ext >= cnt_ext) begin
                    status_next = blist_pkg::ST_RANGE;
                end else begin
                    rd_next  = 1'b1;
                    ram_en   = 1'b1;
                    ram_addr = wrap_pos;
                end
            end
            blist_pkg::KIND_TAKE: begin
                if (n_ext <= cnt_ext) begin
                    count_next = CW'(n_ext);
                end
            end
            blist_pkg::KIND_DROP: begin
                if (n_ext >= cnt_ext) begin
                    count_next = '0;
                end else begin
                    front_next = wrap_pos;
                    count_next = count_reg - CW'(n_ext);
                end
            end
            default: begin
                // unused kind: report the list as it stands
            end
        endcase
    end

    assign cnt_next_ext = SW'(count_next);

    // Element memory
    blist_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en && accept),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value),
        .rdata (ram_q)
    );

    // List state and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg     <= rd_next;
            length_reg <= cnt_next_ext[LW-1:0];
            empty_reg  <= (count_next == '0);
            status_reg <= status_next;
        end
    end

    // Result beat
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, status_reg, empty_reg, length_reg,
                       (rd_reg ? ram_q : {DW{1'b0}})};

endmodule

`default_nettype wire

### hdl/blist_ram.sv
// ----------------------------------------------------------------------------
// blist_ram
// Generic single-port RAM: one access per cycle, write or registered read.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module blist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
